/* src/line_follow_pid_steer_defines.svh */
// Assertion macros shared by the steering block.
`ifndef LINE_FOLLOW_PID_STEER_DEFINES_SVH
`define LINE_FOLLOW_PID_STEER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LFPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LFPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lfps_pkg.sv */
// Types and constants for the line-follow PID steering block.
package lfps_pkg;

  localparam int unsigned POS_W   = 12;
  localparam int unsigned LEVEL_W = 10;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SPEED_W = 7;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned UNITS_W = 24;

  localparam logic [POS_W-1:0] POS_MAX    = 12'd4000;
  localparam logic [POS_W-1:0] CENTER_POS = 12'd2000;

  // err / 20 for |err| <= 2000
  localparam logic [11:0] P_RECIP = 12'd3277;
  localparam int unsigned P_SHIFT = 16;
  // sum / 10000 for any 32-bit magnitude
  localparam logic [31:0] I_RECIP = 32'hD1B7_1759;
  localparam int unsigned I_SHIFT = 45;
  // elapsed / 500 for any 32-bit value
  localparam logic [31:0] T_RECIP = 32'd2199023256;
  localparam int unsigned T_SHIFT = 40;

  localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 7'd60;
  localparam logic [LEVEL_W-1:0] DEAD_END_RST   = 10'd100;
  localparam logic [LEVEL_W-1:0] SIDE_THRESH_RST = 10'd200;

  typedef enum logic [1:0] {
    CFG_MAX_SPEED   = 2'd0,
    CFG_DEAD_END    = 2'd1,
    CFG_SIDE_THRESH = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    STOP_NONE     = 2'd0,
    STOP_DEAD_END = 2'd1,
    STOP_SIDE     = 2'd2
  } stop_reason_e;

endpackage

/* src/line_follow_pid_steer.sv */
// Line-follow PID steering with dead-end and intersection detection.
// A result goes through four register stages (A, B, C, D) after its input transfer.
// One sample per cycle unless stalled; the error state updates when A passes to B.
// Pipeline stalls only when all four stages are full and the output is stalled.
// Reset clears the error state, start time, stage valids and loads default settings.
`include "line_follow_pid_steer_defines.svh"
module line_follow_pid_steer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_index_i,
  input  logic [lfps_pkg::LEVEL_W-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                start_run_i,
  input  logic [lfps_pkg::POS_W-1:0]          line_position_i,
  input  logic [lfps_pkg::LEVEL_W-1:0]        left_outer_level_i,
  input  logic [lfps_pkg::LEVEL_W-1:0]        left_inner_level_i,
  input  logic [lfps_pkg::LEVEL_W-1:0]        middle_level_i,
  input  logic [lfps_pkg::LEVEL_W-1:0]        right_inner_level_i,
  input  logic [lfps_pkg::LEVEL_W-1:0]        right_outer_level_i,
  input  logic [lfps_pkg::TIME_W-1:0]         time_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lfps_pkg::SPEED_W-1:0]        left_drive_o,
  output logic [lfps_pkg::SPEED_W-1:0]        right_drive_o,
  output logic                                finished_o,
  output logic [1:0]                          stop_reason_o,
  output logic [lfps_pkg::UNITS_W-1:0]        elapsed_units_o
);

  // configuration
  logic [lfps_pkg::SPEED_W-1:0] max_speed_q;
  logic [lfps_pkg::LEVEL_W-1:0] dead_end_q;
  logic [lfps_pkg::LEVEL_W-1:0] side_thresh_q;

  // state
  logic signed [11:0]           prev_err_q;
  logic signed [31:0]           err_sum_q;
  logic [lfps_pkg::TIME_W-1:0]  start_time_q;

  // stage A: input register
  logic                         a_vld_q;
  logic                         a_start_q;
  logic [lfps_pkg::POS_W-1:0]   a_pos_q;
  logic [lfps_pkg::LEVEL_W-1:0] a_lo_q, a_li_q, a_mid_q, a_ri_q, a_ro_q;
  logic [lfps_pkg::TIME_W-1:0]  a_time_q;

  // stage B
  logic                         b_vld_q;
  logic signed [11:0]           b_err_q;
  logic signed [31:0]           b_sum_q;
  logic signed [13:0]           b_d3_q;
  logic [31:0]                  b_elapsed_q;
  lfps_pkg::stop_reason_e       b_reason_q;

  // stage C
  logic                         c_vld_q;
  logic [6:0]                   c_pq_q;
  logic                         c_psign_q;
  logic [17:0]                  c_iq_q;
  logic                         c_isign_q;
  logic signed [13:0]           c_d3_q;
  logic [lfps_pkg::UNITS_W-1:0] c_units_q;
  lfps_pkg::stop_reason_e       c_reason_q;

  // stage D: output register
  logic                         d_vld_q;
  logic [lfps_pkg::SPEED_W-1:0] d_left_q, d_right_q;
  logic [lfps_pkg::UNITS_W-1:0] d_units_q;
  lfps_pkg::stop_reason_e       d_reason_q;

  logic en_a, en_b, en_c, en_d;

  assign en_d = !d_vld_q || !out_stall_i;
  assign en_c = !c_vld_q || en_d;
  assign en_b = !b_vld_q || en_c;
  assign en_a = !a_vld_q || en_b;

  assign in_stall_o  = !en_a;
  assign cfg_ready_o = 1'b1;

  // ---------------- A -> B ----------------
  logic [lfps_pkg::POS_W-1:0]   pos_sat;
  logic signed [11:0]           err_d;
  logic signed [11:0]           prev_eff;
  logic signed [31:0]           sum_eff;
  logic signed [12:0]           diff;
  logic signed [14:0]           diff_ext, diff3, diff3_rnd;
  logic signed [13:0]           d3_half;
  logic signed [32:0]           sum33;
  logic signed [31:0]           sum_d;
  logic [31:0]                  elapsed_d;
  logic                         dead_end, side_hit;
  lfps_pkg::stop_reason_e       reason_d;
  logic                         adv_b;

  always_comb begin
    pos_sat   = (a_pos_q > lfps_pkg::POS_MAX) ? lfps_pkg::POS_MAX : a_pos_q;
    err_d     = signed'(pos_sat - lfps_pkg::CENTER_POS);
    prev_eff  = a_start_q ? 12'sd0 : prev_err_q;
    sum_eff   = a_start_q ? 32'sd0 : err_sum_q;
    diff      = {err_d[11], err_d} - {prev_eff[11], prev_eff};
    diff_ext  = {{2{diff[12]}}, diff};
    diff3     = (diff_ext <<< 1) + diff_ext;
    diff3_rnd = diff3 + {14'd0, diff3[14]};
    d3_half   = diff3_rnd[14:1];
    sum33     = {sum_eff[31], sum_eff} + {{21{err_d[11]}}, err_d};
    if (sum33[32] != sum33[31]) begin
      sum_d = sum33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sum_d = sum33[31:0];
    end
    elapsed_d = a_start_q ? 32'd0 : (a_time_q - start_time_q);
    dead_end  = (a_li_q < dead_end_q) && (a_mid_q < dead_end_q) && (a_ri_q < dead_end_q);
    side_hit  = (a_lo_q > side_thresh_q) || (a_ro_q > side_thresh_q);
    priority if (dead_end) begin
      reason_d = lfps_pkg::STOP_DEAD_END;
    end else if (side_hit) begin
      reason_d = lfps_pkg::STOP_SIDE;
    end else begin
      reason_d = lfps_pkg::STOP_NONE;
    end
  end

  assign adv_b = a_vld_q && en_b;

  // ---------------- B -> C ----------------
  logic [10:0] err_mag;
  logic [22:0] p_prod;
  logic [31:0] sum_mag;
  logic [63:0] i_prod;
  logic [63:0] t_prod;
  logic [11:0] err_neg;

  always_comb begin
    err_neg = 12'(-b_err_q);
    err_mag = b_err_q[11] ? err_neg[10:0] : b_err_q[10:0];
    p_prod  = err_mag * lfps_pkg::P_RECIP;
    sum_mag = b_sum_q[31] ? 32'(-b_sum_q) : 32'(b_sum_q);
    i_prod  = sum_mag * lfps_pkg::I_RECIP;
    t_prod  = b_elapsed_q * lfps_pkg::T_RECIP;
  end

  // ---------------- C -> D ----------------
  logic signed [19:0] p_val, i_val, total, lim20;
  logic signed [7:0]  corr;
  logic [7:0]         lim8, left8, right8;

  always_comb begin
    p_val = c_psign_q ? -$signed({13'd0, c_pq_q}) : $signed({13'd0, c_pq_q});
    i_val = c_isign_q ? -$signed({2'd0, c_iq_q}) : $signed({2'd0, c_iq_q});
    total = p_val + i_val + {{6{c_d3_q[13]}}, c_d3_q};
    lim20 = $signed({13'd0, max_speed_q});
    if (total > lim20) begin
      corr = lim20[7:0];
    end else if (total < -lim20) begin
      corr = 8'(-lim20);
    end else begin
      corr = total[7:0];
    end
    lim8 = {1'b0, max_speed_q};
    if (corr[7]) begin
      left8  = lim8 + corr;
      right8 = lim8;
    end else begin
      left8  = lim8;
      right8 = lim8 - corr;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q   <= lfps_pkg::MAX_SPEED_RST;
      dead_end_q    <= lfps_pkg::DEAD_END_RST;
      side_thresh_q <= lfps_pkg::SIDE_THRESH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        lfps_pkg::CFG_MAX_SPEED:   max_speed_q   <= cfg_data_i[lfps_pkg::SPEED_W-1:0];
        lfps_pkg::CFG_DEAD_END:    dead_end_q    <= cfg_data_i;
        lfps_pkg::CFG_SIDE_THRESH: side_thresh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q   <= '0;
      err_sum_q    <= '0;
      start_time_q <= '0;
    end else if (adv_b) begin
      prev_err_q <= err_d;
      err_sum_q  <= sum_d;
      if (a_start_q) begin
        start_time_q <= a_time_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      if (en_a) a_vld_q <= in_valid_i;
      if (en_b) b_vld_q <= a_vld_q;
      if (en_c) c_vld_q <= b_vld_q;
      if (en_d) d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && in_valid_i) begin
      a_start_q <= start_run_i;
      a_pos_q   <= line_position_i;
      a_lo_q    <= left_outer_level_i;
      a_li_q    <= left_inner_level_i;
      a_mid_q   <= middle_level_i;
      a_ri_q    <= right_inner_level_i;
      a_ro_q    <= right_outer_level_i;
      a_time_q  <= time_ms_i;
    end
    if (adv_b) begin
      b_err_q     <= err_d;
      b_sum_q     <= sum_d;
      b_d3_q      <= d3_half;
      b_elapsed_q <= elapsed_d;
      b_reason_q  <= reason_d;
    end
    if (b_vld_q && en_c) begin
      c_pq_q     <= p_prod[lfps_pkg::P_SHIFT+6:lfps_pkg::P_SHIFT];
      c_psign_q  <= b_err_q[11];
      c_iq_q     <= i_prod[lfps_pkg::I_SHIFT+17:lfps_pkg::I_SHIFT];
      c_isign_q  <= b_sum_q[31];
      c_d3_q     <= b_d3_q;
      c_units_q  <= t_prod[lfps_pkg::T_SHIFT+23:lfps_pkg::T_SHIFT];
      c_reason_q <= b_reason_q;
    end
    if (c_vld_q && en_d) begin
      d_reason_q <= c_reason_q;
      if (c_reason_q != lfps_pkg::STOP_NONE) begin
        d_left_q  <= '0;
        d_right_q <= '0;
        d_units_q <= c_units_q;
      end else begin
        d_left_q  <= left8[6:0];
        d_right_q <= right8[6:0];
        d_units_q <= '0;
      end
    end
  end

  assign out_valid_o     = d_vld_q;
  assign left_drive_o    = d_left_q;
  assign right_drive_o   = d_right_q;
  assign finished_o      = (d_reason_q != lfps_pkg::STOP_NONE);
  assign stop_reason_o   = d_reason_q;
  assign elapsed_units_o = d_units_q;

  `LFPS_ASSERT_NOW(a_fin_stops, out_valid_o && finished_o, (left_drive_o == '0) && (right_drive_o == '0), "finished result drives wheels")
  `LFPS_ASSERT_NOW(a_drive_base, out_valid_o && !finished_o, (left_drive_o == max_speed_q) || (right_drive_o == max_speed_q), "neither wheel at base drive")
  `LFPS_ASSERT_NEXT(a_start_time, adv_b && a_start_q, start_time_q == $past(a_time_q), "start time not recorded")
  `LFPS_ASSERT_NOW(a_stall_full, in_stall_o, a_vld_q && b_vld_q && c_vld_q && d_vld_q && out_stall_i, "stall with a free stage")

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the line-follow PID steering block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned RAMP_SAMPLES = 100;
  localparam int unsigned QUEUE_FILL   = 64;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_ITEMS  = 180;

  typedef logic [lfps_pkg::POS_W-1:0]   pos_t;
  typedef logic [lfps_pkg::LEVEL_W-1:0] level_t;
  typedef logic [lfps_pkg::TIME_W-1:0]  ms_t;
  typedef logic [lfps_pkg::SPEED_W-1:0] speed_t;
  typedef logic [lfps_pkg::UNITS_W-1:0] units_t;

  typedef struct packed {
    logic   start;
    pos_t   pos;
    level_t lo;
    level_t li;
    level_t mid;
    level_t ri;
    level_t ro;
    ms_t    now;
  } sample_t;

  typedef struct packed {
    speed_t                 left;
    speed_t                 right;
    logic                   finished;
    lfps_pkg::stop_reason_e reason;
    units_t                 units;
  } steer_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  lfps_pkg::cfg_index_e cfg_index = lfps_pkg::CFG_MAX_SPEED;
  level_t               cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 start_run = 1'b0;
  pos_t                 line_position = '0;
  level_t               left_outer = '0;
  level_t               left_inner = '0;
  level_t               middle = '0;
  level_t               right_inner = '0;
  level_t               right_outer = '0;
  ms_t                  time_ms = '0;
  logic                 out_stall = 1'b0;

  logic                 cfg_ready;
  logic                 in_stall;
  logic                 out_valid;
  speed_t               left_drive;
  speed_t               right_drive;
  logic                 finished;
  logic [1:0]           stop_reason;
  units_t               elapsed_units;

  // Predictor state and register copies
  int                   prev_err = 0;
  int                   err_sum = 0;
  ms_t                  run_start = '0;
  speed_t               spd_lim = lfps_pkg::MAX_SPEED_RST;
  level_t               dead_lvl = lfps_pkg::DEAD_END_RST;
  level_t               side_lvl = lfps_pkg::SIDE_THRESH_RST;

  sample_t              pending_samples[$];
  steer_t               expected_steer[$];
  sample_t              presented;
  ms_t                  now_ms = '0;
  int unsigned          send_idle_pct = 0;
  int unsigned          recv_stall_pct = 0;
  logic                 hold_on = 1'b0;
  event                 hold_go;
  int unsigned          mismatch_cnt = 0;
  int unsigned          cycle_cnt = 0;

  line_follow_pid_steer uut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .start_run_i         (start_run),
    .line_position_i     (line_position),
    .left_outer_level_i  (left_outer),
    .left_inner_level_i  (left_inner),
    .middle_level_i      (middle),
    .right_inner_level_i (right_inner),
    .right_outer_level_i (right_outer),
    .time_ms_i           (time_ms),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .left_drive_o        (left_drive),
    .right_drive_o       (right_drive),
    .finished_o          (finished),
    .stop_reason_o       (stop_reason),
    .elapsed_units_o     (elapsed_units)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic steer_t steer_predict(sample_t s);
    int     err;
    int     diff;
    int     lim;
    longint acc;
    pos_t   pos;
    ms_t    span;
    steer_t r;
    if (s.start) begin
      err_sum = 0;
      prev_err = 0;
      run_start = s.now;
    end
    pos = (s.pos > lfps_pkg::POS_MAX) ? lfps_pkg::POS_MAX : s.pos;
    err = int'(pos) - int'(lfps_pkg::CENTER_POS);
    diff = err - prev_err;
    acc = longint'(err_sum) + longint'(err);
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    err_sum = int'(acc);
    prev_err = err;
    acc = longint'(err / 20) + longint'(err_sum / 10000) + longint'((diff * 3) / 2);
    lim = int'(spd_lim);
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    if (acc < 0) begin
      r.left = speed_t'(lim + int'(acc));
      r.right = speed_t'(lim);
    end else begin
      r.left = speed_t'(lim);
      r.right = speed_t'(lim - int'(acc));
    end
    r.reason = lfps_pkg::STOP_NONE;
    if (s.li < dead_lvl && s.mid < dead_lvl && s.ri < dead_lvl)
      r.reason = lfps_pkg::STOP_DEAD_END;
    else if (s.lo > side_lvl || s.ro > side_lvl)
      r.reason = lfps_pkg::STOP_SIDE;
    r.finished = (r.reason != lfps_pkg::STOP_NONE);
    r.units = '0;
    if (r.finished) begin
      span = s.now - run_start;
      r.left = '0;
      r.right = '0;
      r.units = units_t'(span / 32'd500);
    end
    return r;
  endfunction

  function automatic sample_t mk(logic st, pos_t pos, level_t lo, level_t li, level_t mid,
                                 level_t ri, level_t ro, ms_t now);
    sample_t s;
    s = '{st, pos, lo, li, mid, ri, ro, now};
    return s;
  endfunction

  function automatic sample_t random_sample();
    sample_t     s;
    int unsigned mode;
    mode = $urandom_range(9);
    s.start = ($urandom_range(24) == 0);
    s.pos = ($urandom_range(19) == 0) ? pos_t'($urandom_range(4095, 4001))
                                      : pos_t'($urandom_range(4000));
    s.lo = level_t'($urandom_range(1023));
    s.li = level_t'($urandom_range(1023));
    s.mid = level_t'($urandom_range(1023));
    s.ri = level_t'($urandom_range(1023));
    s.ro = level_t'($urandom_range(1023));
    if (mode < 6) begin
      s.lo = level_t'($urandom_range(side_lvl));
      s.ro = level_t'($urandom_range(side_lvl));
      s.mid = level_t'($urandom_range(1023, dead_lvl));
    end else if (mode < 8 && dead_lvl != 0) begin
      s.li = level_t'($urandom_range(dead_lvl - 1));
      s.mid = level_t'($urandom_range(dead_lvl - 1));
      s.ri = level_t'($urandom_range(dead_lvl - 1));
    end else if (mode == 8) begin
      s.li = dead_lvl;
      s.mid = dead_lvl - 1'b1;
      s.ri = level_t'($urandom_range(dead_lvl));
      s.lo = side_lvl;
      s.ro = side_lvl + level_t'($urandom_range(1));
    end
    if ($urandom_range(99) == 0) now_ms = $urandom();
    else now_ms = now_ms + $urandom_range(2000, 1);
    s.now = now_ms;
    return s;
  endfunction

  task automatic push(sample_t s);
    while (pending_samples.size() >= QUEUE_FILL) @(posedge clk);
    pending_samples.push_back(s);
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid || expected_steer.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(lfps_pkg::cfg_index_e idx, level_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lfps_pkg::CFG_MAX_SPEED:   spd_lim = val[lfps_pkg::SPEED_W-1:0];
      lfps_pkg::CFG_DEAD_END:    dead_lvl = val;
      lfps_pkg::CFG_SIDE_THRESH: side_lvl = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drive samples; predict at each input transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_steer.push_back(steer_predict(presented));
      if (in_valid && in_stall) begin
      end else if (pending_samples.size() != 0 &&
                   !(send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)) begin
        presented = pending_samples.pop_front();
        start_run <= presented.start;
        line_position <= presented.pos;
        left_outer <= presented.lo;
        left_inner <= presented.li;
        middle <= presented.mid;
        right_inner <= presented.ri;
        right_outer <= presented.ro;
        time_ms <= presented.now;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Check each output transfer against the oldest prediction
  always @(posedge clk) begin
    steer_t got;
    steer_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.left = left_drive;
        got.right = right_drive;
        got.finished = finished;
        got.reason = lfps_pkg::stop_reason_e'(stop_reason);
        got.units = elapsed_units;
        if (expected_steer.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected result L=%0d R=%0d fin=%0d why=%0d u=%0d",
                     $realtime, got.left, got.right, got.finished, got.reason, got.units);
        end else begin
          want = expected_steer.pop_front();
          if (got.left !== want.left || got.right !== want.right ||
              got.finished !== want.finished || got.reason !== want.reason ||
              got.units !== want.units) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                       $realtime, want.left, want.right, want.finished, want.reason,
                       want.units, got.left, got.right, got.finished, got.reason, got.units);
          end
        end
      end
      out_stall <= hold_on || (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // Hold the output for a long stretch while samples keep coming
  always begin
    @(hold_go);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples at reset settings, then at changed settings
    push(mk(1'b1, 12'd2000, 10'd0, 10'd500, 10'd900, 10'd500, 10'd0, 32'd1000));
    push(mk(1'b0, 12'd0, 10'd0, 10'd500, 10'd900, 10'd500, 10'd0, 32'd1010));
    push(mk(1'b0, 12'd4000, 10'd0, 10'd500, 10'd900, 10'd500, 10'd0, 32'd1020));
    push(mk(1'b0, 12'd4095, 10'd0, 10'd500, 10'd900, 10'd500, 10'd0, 32'd1030));
    push(mk(1'b0, 12'd4001, 10'd0, 10'd500, 10'd900, 10'd500, 10'd0, 32'd1040));
    push(mk(1'b0, 12'd1000, 10'd0, 10'd99, 10'd0, 10'd50, 10'd0, 32'd3000));
    push(mk(1'b0, 12'd2500, 10'd1000, 10'd500, 10'd900, 10'd500, 10'd0, 32'd4000));
    push(mk(1'b0, 12'd2500, 10'd0, 10'd500, 10'd900, 10'd500, 10'd201, 32'd5000));
    push(mk(1'b0, 12'd1500, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd1023, 32'd6000));
    push(mk(1'b0, 12'd3000, 10'd200, 10'd100, 10'd100, 10'd100, 10'd200, 32'd6500));
    push(mk(1'b1, 12'd1999, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd0, 32'hFFFF_FF00));
    push(mk(1'b0, 12'd2001, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 32'h0000_1000));
    push(mk(1'b1, 12'd4000, 10'd0, 10'd600, 10'd600, 10'd600, 10'd0, 32'd0));
    push(mk(1'b0, 12'd0, 10'd0, 10'd600, 10'd600, 10'd600, 10'd1000, 32'hFFFF_FFFF));
    wait_idle();
    set_reg(lfps_pkg::CFG_MAX_SPEED, 10'd0);
    push(mk(1'b0, 12'd0, 10'd0, 10'd600, 10'd600, 10'd600, 10'd0, 32'd100));
    push(mk(1'b0, 12'd4000, 10'd0, 10'd600, 10'd600, 10'd600, 10'd0, 32'd200));
    wait_idle();
    set_reg(lfps_pkg::CFG_MAX_SPEED, 10'd127);
    set_reg(lfps_pkg::CFG_DEAD_END, 10'd0);
    set_reg(lfps_pkg::CFG_SIDE_THRESH, 10'd0);
    push(mk(1'b1, 12'd3000, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 32'd500));
    push(mk(1'b0, 12'd100, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 32'd600));
    push(mk(1'b0, 12'd2000, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1, 32'd1500));
    wait_idle();
    set_reg(lfps_pkg::CFG_DEAD_END, 10'd1000);
    set_reg(lfps_pkg::CFG_SIDE_THRESH, 10'd1000);
    push(mk(1'b0, 12'd2200, 10'd1000, 10'd999, 10'd999, 10'd999, 10'd1000, 32'd1600));
    push(mk(1'b0, 12'd2200, 10'd1000, 10'd999, 10'd1000, 10'd999, 10'd1000, 32'd1700));
    push(mk(1'b0, 12'd2200, 10'd1001, 10'd1000, 10'd1000, 10'd1000, 10'd0, 32'd2700));
    wait_idle();

    // Build up a large error sum, then pull it back
    set_reg(lfps_pkg::CFG_MAX_SPEED, level_t'(lfps_pkg::MAX_SPEED_RST));
    set_reg(lfps_pkg::CFG_DEAD_END, level_t'(lfps_pkg::DEAD_END_RST));
    set_reg(lfps_pkg::CFG_SIDE_THRESH, level_t'(lfps_pkg::SIDE_THRESH_RST));
    for (int unsigned i = 0; i < RAMP_SAMPLES; i++)
      push(mk(i == 0, 12'd4000, 10'd0, 10'd500, 10'd1000, 10'd500, 10'd0, 32'(i)));
    for (int unsigned i = 0; i < 10; i++)
      push(mk(1'b0, 12'd0, 10'd0, 10'd500, 10'd1000, 10'd500, 10'd0, 32'(RAMP_SAMPLES + i)));
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        1: begin
          set_reg(lfps_pkg::CFG_MAX_SPEED, 10'd127);
          set_reg(lfps_pkg::CFG_DEAD_END, 10'd1000);
          set_reg(lfps_pkg::CFG_SIDE_THRESH, 10'd0);
        end
        2: begin
          set_reg(lfps_pkg::CFG_MAX_SPEED, 10'd1);
          set_reg(lfps_pkg::CFG_DEAD_END, 10'd0);
          set_reg(lfps_pkg::CFG_SIDE_THRESH, 10'd1000);
        end
        3, 5: begin
          set_reg(lfps_pkg::CFG_MAX_SPEED, level_t'($urandom_range(127, 1)));
          set_reg(lfps_pkg::CFG_DEAD_END, level_t'($urandom_range(1000)));
          set_reg(lfps_pkg::CFG_SIDE_THRESH, level_t'($urandom_range(1000)));
        end
        4: begin
          set_reg(lfps_pkg::CFG_MAX_SPEED, 10'd0);
          set_reg(lfps_pkg::CFG_DEAD_END, level_t'($urandom_range(1000)));
          set_reg(lfps_pkg::CFG_SIDE_THRESH, level_t'($urandom_range(1000)));
        end
        default: ;
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        push(random_sample());
        if (p == 0 && i == 60) -> hold_go;
      end
      wait_idle();
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end

    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && expected_steer.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
